// ----- hdl/skq_pkg.sv -----
// ----------------------------------------------------------------------------
// skq_pkg: shared types and constants for the k-th largest selector
// Store depth, derived widths and the structs that link neighboring cells.
// ----------------------------------------------------------------------------
`default_nettype none

package skq_pkg;

  localparam int MAX_KEEP = 16;
  localparam int DATA_W   = 32;
  // fill count and rank hold 0..MAX_KEEP
  localparam int KEEP_W   = $clog2(MAX_KEEP + 1);
  // cell index 0..MAX_KEEP-1
  localparam int IDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  // What a cell hands to its right neighbor (current contents and its compare)
  typedef struct packed {
    logic                     valid;
    logic                     take;
    logic signed [DATA_W-1:0] value;
  } skq_link_t;

  // Row-wide control, the same for every cell
  typedef struct packed {
    logic ins;  // a sample is inserted this cycle
    logic clr;  // the row is emptied this cycle
  } skq_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/skq_cell.sv -----
// ----------------------------------------------------------------------------
// skq_cell: one slot of the sorted insertion row
// Holds one kept value; the row is ordered largest first. On insert the
// cell keeps its value, takes the new sample, or takes its left neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module skq_cell (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire skq_pkg::skq_ctrl_t             ctrl,
  input  wire logic signed [skq_pkg::DATA_W-1:0] sample,
  input  wire skq_pkg::skq_link_t             left,
  output skq_pkg::skq_link_t                  right,
  output logic signed [skq_pkg::DATA_W-1:0]   ins_value
);
  import skq_pkg::*;

  logic                     valid;
  logic signed [DATA_W-1:0] value;
  logic                     take;
  logic                     ins_valid;

  // empty slot or smaller value: the sample goes at or left of here
  assign take = !valid || (sample > value);

  always_comb begin
    if (take) begin
      ins_value = left.take ? left.value : sample;
      ins_valid = left.take ? left.valid : 1'b1;
    end else begin
      ins_value = value;
      ins_valid = valid;
    end
  end

  assign right.valid = valid;
  assign right.take  = take;
  assign right.value = value;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      valid <= 1'b0;
    end else if (ctrl.ins) begin
      valid <= ins_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      value <= ins_value;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/streaming_kth_largest_select.sv -----
// ----------------------------------------------------------------------------
// streaming_kth_largest_select: k-th largest value of each set in a stream
// Keeps the k largest samples of the running set in a sorted row of cells
// and reports the smallest of them when the set ends.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one signed sample per transaction,
//    end_of_set marks the last sample of a set. One sample per cycle is
//    accepted while in_stall is low; the cell row inserts it as it is accepted.
//  - Output channel (out_valid / out_stall): one transaction per set, on its
//    last sample. kth_value is the k-th largest sample; too_few flags a set
//    shorter than k, and kth_value is then the smallest sample of the set.
//    The result appears in the cycle after the last sample is accepted.
//  - Config channel (cfg_valid / cfg_ready, keep_count): sets k. Zero acts
//    as 1, values above the store depth act as the depth. A write empties
//    the store and drops any set in progress. cfg_ready is always high.
//  - Throughput: 1 sample per cycle while in_stall is low. in_stall rises only
//    while a result waits in the output register and the receiver stalls it.
//  - Reset (rst, synchronous): k = 1, store empty, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module streaming_kth_largest_select (
  input  wire                                   clk,
  input  wire                                   rst,
  // sample channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire logic signed [skq_pkg::DATA_W-1:0] sample_value,
  input  wire                                   end_of_set,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [skq_pkg::DATA_W-1:0]     kth_value,
  output logic                                  too_few,
  // configuration
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [4:0]                       keep_count
);
  import skq_pkg::*;

  skq_ctrl_t                ctrl;
  skq_link_t                links [MAX_KEEP+1];
  logic signed [DATA_W-1:0] ins_values [MAX_KEEP];
  logic [MAX_KEEP-1:0]      valid_vec;

  logic              in_accept;
  logic              cfg_write;
  logic [KEEP_W-1:0] rank;        // effective k, 1..MAX_KEEP
  logic [KEEP_W-1:0] rank_next;
  logic [KEEP_W-1:0] fill;        // samples kept so far, saturates at rank
  logic [KEEP_W-1:0] fill_next;
  logic [KEEP_W-1:0] sel_full;
  logic [IDX_W-1:0]  sel;

  // Output register parts the two sides; stall only when it is held
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign ctrl.ins = in_accept;
  assign ctrl.clr = (in_accept && end_of_set) || cfg_write;

  // Clamp the written rank into 1..MAX_KEEP
  always_comb begin
    if (32'(keep_count) > 32'(MAX_KEEP)) begin
      rank_next = KEEP_W'(MAX_KEEP);
    end else if (keep_count == 5'd0) begin
      rank_next = KEEP_W'(1);
    end else begin
      rank_next = KEEP_W'(keep_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= KEEP_W'(1);
    end else if (cfg_write) begin
      rank <= rank_next;
    end
  end

  // Cell row: cell 0 has no left neighbor that could hand it a value
  assign links[0] = '0;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    skq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .sample    (sample_value),
      .left      (links[i]),
      .right     (links[i+1]),
      .ins_value (ins_values[i])
    );
    assign valid_vec[i] = links[i+1].valid;
  end

  // Fill count after this sample; the k-th largest (or the smallest of a
  // short set) then sits in cell fill_next-1 of the updated row.
  assign fill_next = (fill < rank) ? fill + KEEP_W'(1) : fill;
  assign sel_full  = fill_next - KEEP_W'(1);
  assign sel       = sel_full[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      fill <= '0;
    end else if (in_accept) begin
      fill <= fill_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && end_of_set) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && end_of_set) begin
      kth_value <= ins_values[sel];
      too_few   <= (fill_next < rank);
    end
  end

`ifndef SYNTHESIS
  // A set's last sample always leaves a result behind
  a_result_follows_end: assert property (@(posedge clk) disable iff (rst)
    in_accept && end_of_set |=> out_valid)
    else $error("no result after end of set");

  // The fill count never passes the rank
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= rank)
    else $error("fill count above rank");

  // Occupied cells form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + MAX_KEEP'(1)) & valid_vec) == '0)
    else $error("gap in occupied cells");

  // Kept samples in the row: the row holds at least fill entries
  a_fill_in_row: assert property (@(posedge clk) disable iff (rst)
    fill != '0 |-> valid_vec[IDX_W'(fill - KEEP_W'(1))])
    else $error("fill count points at an empty cell");
`endif

endmodule

`default_nettype wire
